>>> sv/scc_pkg.sv
// Shared types, constants and helpers of the sector cache directory.
`timescale 1ns / 1ps
`default_nettype none
package scc_pkg;

	localparam int NUM_SLOTS  = 64;
	localparam int SLOT_W     = $clog2(NUM_SLOTS);
	localparam int USE_W      = SLOT_W + 1;
	localparam int CNT_W      = $clog2(2 * NUM_SLOTS) + 1;
	localparam int TAG_W      = 32;
	localparam int CMD_W      = 2;
	localparam int SLOT_OUT_W = 6;
	localparam int META_W     = 2;

	localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

	typedef struct packed {
		logic accessed;
		logic dirty;
	} meta_t;

	typedef struct packed {
		logic              re;
		logic [SLOT_W-1:0] raddr;
		logic              we;
		logic [SLOT_W-1:0] waddr;
		logic [TAG_W-1:0]  wdata;
	} tag_port_t;

	typedef struct packed {
		logic              re;
		logic [SLOT_W-1:0] raddr;
		logic              we;
		logic [SLOT_W-1:0] waddr;
		meta_t             wdata;
	} meta_port_t;

	typedef struct packed {
		logic [SLOT_OUT_W-1:0] slot;
		logic                  hit;
		logic                  fetch_needed;
		logic                  writeback_valid;
		logic [TAG_W-1:0]      writeback_sector;
		logic                  last;
	} scc_result_t;

	// Advance a slot index around the ring.
	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(NUM_SLOTS - 1)) ? '0 : s + 1'b1;
	endfunction

endpackage
`default_nettype wire

>>> sv/scc_if.sv
// Request and result channel interfaces of the sector cache directory.
`timescale 1ns / 1ps
`default_nettype none
interface scc_req_if import scc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] cmd;
	logic [TAG_W-1:0] sector;

	modport source (output valid, output cmd, output sector, input ready);
	modport sink (input valid, input cmd, input sector, output ready);
endinterface

interface scc_res_if import scc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [SLOT_OUT_W-1:0] slot;
	logic                  hit;
	logic                  fetch_needed;
	logic                  writeback_valid;
	logic [TAG_W-1:0]      writeback_sector;
	logic                  last;

	modport source (output valid, output slot, output hit, output fetch_needed,
		output writeback_valid, output writeback_sector, output last, input ready);
	modport sink (input valid, input slot, input hit, input fetch_needed,
		input writeback_valid, input writeback_sector, input last, output ready);
endinterface
`default_nettype wire

>>> sv/scc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module scc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> sv/scc_out_reg.sv
// Result output register between the sequencer and the result channel.
`timescale 1ns / 1ps
`default_nettype none
module scc_out_reg import scc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        ld,
	input  wire scc_result_t d,
	output logic             free,
	scc_res_if.source        res
);

	logic        vld_q;
	scc_result_t res_q;

	assign free = !vld_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ld) begin
			vld_q <= 1'b1;
		end else if (res.ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			res_q <= d;
		end
	end

	assign res.valid            = vld_q;
	assign res.slot             = res_q.slot;
	assign res.hit              = res_q.hit;
	assign res.fetch_needed     = res_q.fetch_needed;
	assign res.writeback_valid  = res_q.writeback_valid;
	assign res.writeback_sector = res_q.writeback_sector;
	assign res.last             = res_q.last;

endmodule
`default_nettype wire

>>> sv/scc_seq.sv
// Sequencer: tag lookup scan, slot fill, clock victim sweep and flush walk.
`timescale 1ns / 1ps
`default_nettype none
module scc_seq import scc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	scc_req_if.sink                req,
	output tag_port_t              tag_p,
	input  wire logic [TAG_W-1:0]  tag_rdata,
	output meta_port_t             meta_p,
	input  wire logic [META_W-1:0] meta_rdata,
	output logic                   res_ld,
	output scc_result_t            res_d,
	input  wire logic              res_free
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOOK  = 3'd1;
	localparam logic [2:0] ST_FILL  = 3'd2;
	localparam logic [2:0] ST_SWEEP = 3'd3;
	localparam logic [2:0] ST_FLUSH = 3'd4;

	logic [2:0]        state_q, state_d;
	logic [USE_W-1:0]  used_q, used_d;
	logic [SLOT_W-1:0] hand_q, hand_d;
	logic [USE_W-1:0]  scan_q, scan_d;
	logic [SLOT_W-1:0] swp_idx_q, swp_idx_d;
	logic [CNT_W-1:0]  swp_cnt_q, swp_cnt_d;
	logic              vld_s1, vld_d;
	logic [SLOT_W-1:0] idx_s1, idx_d;
	logic [CNT_W-1:0]  cnt_s1, cnt_d;
	logic [TAG_W-1:0]  sector_q;
	logic              wr_q;
	logic              ld_req;

	meta_t meta_rd;
	logic  tag_hit;
	logic  phase1;
	logic  vic;
	logic  flush_last;

	assign req.ready  = (state_q == ST_IDLE);
	assign meta_rd    = meta_t'(meta_rdata);
	assign tag_hit    = vld_s1 && (tag_rdata == sector_q);
	assign phase1     = cnt_s1 < CNT_W'(NUM_SLOTS - 1);
	// first N-1 slots want clean and unaccessed; later any unaccessed slot
	assign vic        = vld_s1 && (phase1 ? (!meta_rd.accessed && !meta_rd.dirty)
		: !meta_rd.accessed);
	assign flush_last = (USE_W'(idx_s1) + 1'b1) == used_q;

	always_comb begin
		state_d   = state_q;
		used_d    = used_q;
		hand_d    = hand_q;
		scan_d    = scan_q;
		swp_idx_d = swp_idx_q;
		swp_cnt_d = swp_cnt_q;
		vld_d     = vld_s1;
		idx_d     = idx_s1;
		cnt_d     = cnt_s1;
		ld_req    = 1'b0;
		tag_p     = '0;
		meta_p    = '0;
		res_ld    = 1'b0;
		res_d     = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					case (req.cmd) inside
						CMD_READ, CMD_WRITE: begin
							ld_req  = 1'b1;
							scan_d  = '0;
							vld_d   = 1'b0;
							state_d = ST_LOOK;
						end
						CMD_FLUSH: begin
							if (used_q != '0) begin
								scan_d  = '0;
								vld_d   = 1'b0;
								state_d = ST_FLUSH;
							end
						end
						default: begin
						end
					endcase
				end
			end

			ST_LOOK: begin
				if (tag_hit) begin
					if (res_free) begin
						res_ld                 = 1'b1;
						res_d.slot             = SLOT_OUT_W'(idx_s1);
						res_d.hit              = 1'b1;
						res_d.last             = 1'b1;
						meta_p.we              = 1'b1;
						meta_p.waddr           = idx_s1;
						meta_p.wdata.accessed  = 1'b1;
						meta_p.wdata.dirty     = meta_rd.dirty || wr_q;
						vld_d                  = 1'b0;
						state_d                = ST_IDLE;
					end
				end else begin
					vld_d = 1'b0;
					if (scan_q < used_q) begin
						tag_p.re     = 1'b1;
						tag_p.raddr  = scan_q[SLOT_W-1:0];
						meta_p.re    = 1'b1;
						meta_p.raddr = scan_q[SLOT_W-1:0];
						vld_d        = 1'b1;
						idx_d        = scan_q[SLOT_W-1:0];
						scan_d       = scan_q + 1'b1;
					end else if (!vld_s1) begin
						if (used_q < USE_W'(NUM_SLOTS)) begin
							state_d = ST_FILL;
						end else begin
							swp_idx_d = hand_q;
							swp_cnt_d = '0;
							state_d   = ST_SWEEP;
						end
					end
				end
			end

			ST_FILL: begin
				if (res_free) begin
					res_ld                = 1'b1;
					res_d.slot            = SLOT_OUT_W'(used_q[SLOT_W-1:0]);
					res_d.fetch_needed    = !wr_q;
					res_d.last            = 1'b1;
					tag_p.we              = 1'b1;
					tag_p.waddr           = used_q[SLOT_W-1:0];
					tag_p.wdata           = sector_q;
					meta_p.we             = 1'b1;
					meta_p.waddr          = used_q[SLOT_W-1:0];
					meta_p.wdata.accessed = 1'b1;
					meta_p.wdata.dirty    = wr_q;
					used_d                = used_q + 1'b1;
					state_d               = ST_IDLE;
				end
			end

			ST_SWEEP: begin
				if (vic) begin
					if (res_free) begin
						res_ld                 = 1'b1;
						res_d.slot             = SLOT_OUT_W'(idx_s1);
						res_d.fetch_needed     = !wr_q;
						res_d.writeback_valid  = meta_rd.dirty;
						res_d.writeback_sector = meta_rd.dirty ? tag_rdata : '0;
						res_d.last             = 1'b1;
						tag_p.we               = 1'b1;
						tag_p.waddr            = idx_s1;
						tag_p.wdata            = sector_q;
						meta_p.we              = 1'b1;
						meta_p.waddr           = idx_s1;
						meta_p.wdata.accessed  = 1'b1;
						meta_p.wdata.dirty     = wr_q;
						hand_d                 = next_slot(idx_s1);
						vld_d                  = 1'b0;
						state_d                = ST_IDLE;
					end
				end else begin
					// past the first N-1 slots, clear the accessed bit of each slot passed
					if (vld_s1 && !phase1) begin
						meta_p.we             = 1'b1;
						meta_p.waddr          = idx_s1;
						meta_p.wdata.accessed = 1'b0;
						meta_p.wdata.dirty    = meta_rd.dirty;
					end
					vld_d = 1'b0;
					if (swp_cnt_q < CNT_W'(2 * NUM_SLOTS)) begin
						tag_p.re     = 1'b1;
						tag_p.raddr  = swp_idx_q;
						meta_p.re    = 1'b1;
						meta_p.raddr = swp_idx_q;
						vld_d        = 1'b1;
						idx_d        = swp_idx_q;
						cnt_d        = swp_cnt_q;
						swp_idx_d    = next_slot(swp_idx_q);
						swp_cnt_d    = swp_cnt_q + 1'b1;
					end
				end
			end

			ST_FLUSH: begin
				if (vld_s1 && res_free) begin
					res_ld                 = 1'b1;
					res_d.slot             = SLOT_OUT_W'(idx_s1);
					res_d.writeback_valid  = 1'b1;
					res_d.writeback_sector = tag_rdata;
					res_d.last             = flush_last;
					meta_p.we              = 1'b1;
					meta_p.waddr           = idx_s1;
					meta_p.wdata           = '0;
					if (flush_last) begin
						state_d = ST_IDLE;
					end
				end
				if (!vld_s1 || res_free) begin
					vld_d = 1'b0;
					if (scan_q < used_q) begin
						tag_p.re     = 1'b1;
						tag_p.raddr  = scan_q[SLOT_W-1:0];
						vld_d        = 1'b1;
						idx_d        = scan_q[SLOT_W-1:0];
						scan_d       = scan_q + 1'b1;
					end
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			used_q    <= '0;
			hand_q    <= '0;
			scan_q    <= '0;
			swp_idx_q <= '0;
			swp_cnt_q <= '0;
			vld_s1    <= 1'b0;
			idx_s1    <= '0;
			cnt_s1    <= '0;
		end else begin
			state_q   <= state_d;
			used_q    <= used_d;
			hand_q    <= hand_d;
			scan_q    <= scan_d;
			swp_idx_q <= swp_idx_d;
			swp_cnt_q <= swp_cnt_d;
			vld_s1    <= vld_d;
			idx_s1    <= idx_d;
			cnt_s1    <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_req) begin
			sector_q <= req.sector;
			wr_q     <= (req.cmd == CMD_WRITE);
		end
	end

endmodule
`default_nettype wire

>>> sv/sector_cache_clock_replacement.sv
// Top level: tag and enhanced-clock replacement directory of a disk-sector cache.
// A hit is found by a scan of the tag RAM, one slot a cycle; a miss
//   takes the next free slot when one is left, else runs the victim sweep.
// Throughput: one item at a time; a flush gives one item per valid slot,
// one per cycle while the output is free, bound by the tag RAM's single read port.
// Reset clears control, fill count and hand; tag and policy RAMs are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module sector_cache_clock_replacement import scc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	scc_req_if.sink   req,
	scc_res_if.source res
);

	// Directory state:
	//  - tag RAM holds the sector of each slot.
	//  - policy RAM holds accessed and dirty per slot.
	//  - slots fill in order, so a slot is valid exactly when it is below the
	//    fill count kept in the sequencer; no per-slot valid flops and no
	//    clearing pass are needed. A slot that never held a sector is never read.

	tag_port_t         tag_p;
	meta_port_t        meta_p;
	logic [TAG_W-1:0]  tag_rdata;
	logic [META_W-1:0] meta_rdata;
	logic              res_ld;
	scc_result_t       res_d;
	logic              res_free;

	scc_ram #(
		.WIDTH(TAG_W),
		.DEPTH(NUM_SLOTS)
	) u_tag_ram (
		.clk   (clk),
		.we    (tag_p.we),
		.waddr (tag_p.waddr),
		.wdata (tag_p.wdata),
		.re    (tag_p.re),
		.raddr (tag_p.raddr),
		.rdata (tag_rdata)
	);

	scc_ram #(
		.WIDTH(META_W),
		.DEPTH(NUM_SLOTS)
	) u_meta_ram (
		.clk   (clk),
		.we    (meta_p.we),
		.waddr (meta_p.waddr),
		.wdata (meta_p.wdata),
		.re    (meta_p.re),
		.raddr (meta_p.raddr),
		.rdata (meta_rdata)
	);

	// Sequencer: one read in flight at a time; read data stays held while a
	// finished item waits for the output register, so nothing is lost.
	// The victim sweep reads tag and policy together, so a dirty victim's
	// old sector is at hand in the same cycle the victim is found.
	scc_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.tag_p      (tag_p),
		.tag_rdata  (tag_rdata),
		.meta_p     (meta_p),
		.meta_rdata (meta_rdata),
		.res_ld     (res_ld),
		.res_d      (res_d),
		.res_free   (res_free)
	);

	// Output register: the next request is taken while an item waits here.
	scc_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.ld     (res_ld),
		.d      (res_d),
		.free   (res_free),
		.res    (res)
	);

endmodule
`default_nettype wire

>>> test/sector_cache_clock_replacement_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the sector cache tag directory with enhanced clock replacement.
module sector_cache_clock_replacement_test;
	import scc_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 10;
	localparam int CYCLE_LIMIT  = 1_000_000;
	// Drain wait sized to cover a miss with a full two-round sweep.
	localparam int DRAIN_CYCLES = 3 * NUM_SLOTS + 16;
	localparam int POOL_SIZE    = 96;
	localparam int SEGMENTS     = 8;
	localparam int SEGMENT_LEN  = 40;
	localparam int HOLD_AFTER   = 120;
	localparam int HOLD_CYCLES  = 600;
	localparam int MAX_REPORTS  = 10;

	// cmd 3 has no meaning in the package; the block drops it.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [TAG_W-1:0] sector;
	} request_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	scc_req_if req ();
	scc_res_if res ();

	sector_cache_clock_replacement i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.res(res)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Directory mirror: what the block should hold after each item.
	// ------------------------------------------------------------------
	logic [TAG_W-1:0] mirror_tag [NUM_SLOTS];
	logic             mirror_valid [NUM_SLOTS];
	logic             mirror_accessed [NUM_SLOTS];
	logic             mirror_dirty [NUM_SLOTS];
	int unsigned      mirror_hand;
	int unsigned      mirror_fill;

	scc_result_t expected_results [$];
	request_t    pending_requests [$];
	logic [TAG_W-1:0] sector_pool [POOL_SIZE];

	int items_accepted = 0;
	int results_checked = 0;
	int n_errors = 0;
	int n_hits = 0;
	int n_evictions = 0;
	int n_dirty_evictions = 0;
	int n_second_sweep = 0;
	int n_flush_reports = 0;
	int cycle_count = 0;

	// Enhanced clock: first N-1 slots from the hand look for clean and
	// unaccessed; past that any unaccessed slot wins, and every slot
	// passed over loses its accessed bit.
	function automatic int unsigned choose_victim();
		int unsigned i;
		int unsigned idx;
		int unsigned victim;
		victim = mirror_hand;
		for (i = 0; i < 2 * NUM_SLOTS; i++) begin
			idx = (mirror_hand + i) % NUM_SLOTS;
			if (i < NUM_SLOTS - 1) begin
				if (!mirror_accessed[idx] && !mirror_dirty[idx]) begin
					victim = idx;
					break;
				end
			end else begin
				if (!mirror_accessed[idx]) begin
					victim = idx;
					n_second_sweep++;
					break;
				end
				mirror_accessed[idx] = 1'b0;
			end
		end
		mirror_hand = (victim + 1) % NUM_SLOTS;
		return victim;
	endfunction

	// Update the mirror for one accepted item and queue the results it causes.
	function automatic void predict_directory(input logic [CMD_W-1:0] cmd,
			input logic [TAG_W-1:0] sector);
		scc_result_t r;
		int unsigned i;
		int unsigned slot;
		int unsigned reported;
		logic found;
		r = '0;
		if (cmd == CMD_FLUSH) begin
			// one report per valid slot, ascending; empty cache reports nothing
			reported = 0;
			for (i = 0; i < NUM_SLOTS; i++) begin
				if (mirror_valid[i]) begin
					r = '0;
					r.slot = SLOT_OUT_W'(i);
					r.writeback_valid = 1'b1;
					r.writeback_sector = mirror_tag[i];
					mirror_accessed[i] = 1'b0;
					mirror_dirty[i] = 1'b0;
					expected_results.push_back(r);
					reported++;
				end
			end
			if (reported > 0) begin
				r = expected_results.pop_back();
				r.last = 1'b1;
				expected_results.push_back(r);
			end
			n_flush_reports += reported;
			return;
		end
		if (cmd == CMD_UNUSED)
			return;

		found = 1'b0;
		slot = 0;
		for (i = 0; i < NUM_SLOTS; i++) begin
			if (mirror_valid[i] && mirror_tag[i] == sector) begin
				found = 1'b1;
				slot = i;
				break;
			end
		end
		if (found) begin
			n_hits++;
		end else begin
			if (mirror_fill < NUM_SLOTS) begin
				slot = mirror_fill;
				mirror_fill++;
			end else begin
				slot = choose_victim();
				n_evictions++;
				if (mirror_dirty[slot]) begin
					r.writeback_valid = 1'b1;
					r.writeback_sector = mirror_tag[slot];
					n_dirty_evictions++;
				end
			end
			mirror_valid[slot] = 1'b1;
			mirror_tag[slot] = sector;
			mirror_dirty[slot] = 1'b0;
		end
		mirror_accessed[slot] = 1'b1;
		if (cmd == CMD_WRITE)
			mirror_dirty[slot] = 1'b1;
		r.slot = SLOT_OUT_W'(slot);
		r.hit = found;
		r.fetch_needed = !found && (cmd == CMD_READ);
		r.last = 1'b1;
		expected_results.push_back(r);
	endfunction

	task automatic queue_request(input logic [CMD_W-1:0] cmd, input logic [TAG_W-1:0] sector);
		request_t item;
		item.cmd = cmd;
		item.sector = sector;
		pending_requests.push_back(item);
	endtask

	// ------------------------------------------------------------------
	// Driver: bursts of items with random gaps, held until accepted.
	// ------------------------------------------------------------------
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk) begin
		request_t next_item;
		if (arst_n) begin
			if (!req.valid || req.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req.valid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					next_item = pending_requests.pop_front();
					req.valid <= 1'b1;
					req.cmd <= next_item.cmd;
					req.sector <= next_item.sector;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 12);
						// a quarter of bursts run straight into the next
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
					end
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: each mode of random length draws a new ready level; once, a long
	// hold-off while the sender keeps offering.
	// ------------------------------------------------------------------
	int ready_pct = 100;
	int mode_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				res.ready <= 1'b0;
			end else if (!hold_done && items_accepted >= HOLD_AFTER) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				res.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode_left <= $urandom_range(8, 64);
					// levels of 15, 43, 71 and 100 percent
					ready_pct <= 15 + 85 * $urandom_range(0, 3) / 3;
				end else begin
					mode_left <= mode_left - 1;
				end
				res.ready <= ($urandom_range(1, 100) <= ready_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predicts on each accepted request, checks each accepted
	// result against the oldest expectation. One process, so the order
	// of push and pop never depends on the scheduler.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		scc_result_t got;
		scc_result_t want;
		if (arst_n) begin
			if (req.valid && req.ready) begin
				predict_directory(req.cmd, req.sector);
				items_accepted <= items_accepted + 1;
			end
			if (res.valid && res.ready) begin
				got.slot = res.slot;
				got.hit = res.hit;
				got.fetch_needed = res.fetch_needed;
				got.writeback_valid = res.writeback_valid;
				got.writeback_sector = res.writeback_sector;
				got.last = res.last;
				results_checked++;
				if (expected_results.size() == 0) begin
					if (n_errors < MAX_REPORTS)
						$display("ERROR %0t: unexpected item slot=%0d hit=%b fetch=%b wb=%b wbs=%h last=%b",
							$time, got.slot, got.hit, got.fetch_needed, got.writeback_valid,
							got.writeback_sector, got.last);
					n_errors++;
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						if (n_errors < MAX_REPORTS) begin
							$display("ERROR %0t: result %0d mismatch", $time, results_checked);
							$display("  expected slot=%0d hit=%b fetch=%b wb=%b wbs=%h last=%b",
								want.slot, want.hit, want.fetch_needed, want.writeback_valid,
								want.writeback_sector, want.last);
							$display("  actual   slot=%0d hit=%b fetch=%b wb=%b wbs=%h last=%b",
								got.slot, got.hit, got.fetch_needed, got.writeback_valid,
								got.writeback_sector, got.last);
						end
						n_errors++;
					end
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still expected",
				cycle_count, expected_results.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run.
	// ------------------------------------------------------------------
	initial begin
		int unsigned seg;
		int unsigned k;
		int unsigned roll;
		int unsigned write_pct;
		int unsigned fresh_pct;
		int unsigned flush_pct;
		int unsigned pool_span;
		logic [TAG_W-1:0] pick;

		req.valid = 1'b0;
		req.cmd = CMD_READ;
		req.sector = '0;
		res.ready = 1'b0;

		for (k = 0; k < NUM_SLOTS; k++) begin
			mirror_tag[k] = '0;
			mirror_valid[k] = 1'b0;
			mirror_accessed[k] = 1'b0;
			mirror_dirty[k] = 1'b0;
		end
		mirror_hand = 0;
		mirror_fill = 0;

		sector_pool[0] = '0;
		sector_pool[1] = '1;
		for (k = 2; k < POOL_SIZE; k++)
			sector_pool[k] = $urandom;

		// Directed: empty flush, unused command, extreme sectors, hits on
		// clean and dirty slots, flush reports and a hit after a flush.
		queue_request(CMD_FLUSH, 32'h0000_0000);
		queue_request(CMD_UNUSED, 32'hFFFF_FFFF);
		queue_request(CMD_READ, 32'h0000_0000);
		queue_request(CMD_WRITE, 32'hFFFF_FFFF);
		queue_request(CMD_READ, 32'hFFFF_FFFF);
		queue_request(CMD_WRITE, 32'h0000_0000);
		queue_request(CMD_READ, 32'h8000_0000);
		queue_request(CMD_WRITE, 32'h5555_5555);
		queue_request(CMD_WRITE, 32'hAAAA_AAAA);
		queue_request(CMD_UNUSED, 32'h0000_0000);
		queue_request(CMD_FLUSH, 32'hFFFF_FFFF);
		queue_request(CMD_READ, 32'h0000_0000);
		queue_request(CMD_WRITE, 32'h0000_0001);
		queue_request(CMD_FLUSH, 32'h0000_0000);

		// Random: segments with their own write mix, working-set size and
		// share of never-seen sectors, so some phases mostly hit and others
		// thrash the clock through dirty and all-accessed rings.
		for (seg = 0; seg < SEGMENTS; seg++) begin
			write_pct = $urandom_range(5, 95);
			fresh_pct = $urandom_range(0, 25);
			flush_pct = $urandom_range(0, 6);
			pool_span = $urandom_range(20, POOL_SIZE);
			for (k = 0; k < SEGMENT_LEN; k++) begin
				roll = $urandom_range(0, 99);
				if ($urandom_range(0, 99) < fresh_pct)
					pick = $urandom;
				else
					pick = sector_pool[$urandom_range(0, pool_span - 1)];
				if (roll < 2)
					queue_request(CMD_UNUSED, pick);
				else if (roll < 2 + flush_pct)
					queue_request(CMD_FLUSH, pick);
				else if ($urandom_range(0, 99) < write_pct)
					queue_request(CMD_WRITE, pick);
				else
					queue_request(CMD_READ, pick);
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || req.valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		// anything arriving now is unexpected and counted by the monitor
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d items and %0d checked results: %0d hits, %0d evictions",
			items_accepted, results_checked, n_hits, n_evictions);
		$display("(%0d dirty, %0d settled in the second sweep), %0d flush reports, %0d errors",
			n_dirty_evictions, n_second_sweep, n_flush_reports, n_errors);
		if (n_errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> sim.f
sv/scc_pkg.sv
sv/scc_if.sv
sv/scc_ram.sv
sv/scc_out_reg.sv
sv/scc_seq.sv
sv/sector_cache_clock_replacement.sv
test/sector_cache_clock_replacement_test.sv
